@@ src/b64lw_pkg.sv @@
// Shared types and constants for the base64 encoder with line wrap.
// No dependencies; every other file in src refers to it by scoped name.
package b64lw_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_t;

  // Group kinds handed from front to back
  localparam logic [1:0] JOB_FULL = 2'd0;  // four symbols
  localparam logic [1:0] JOB_PAD1 = 2'd1;  // three symbols and one pad
  localparam logic [1:0] JOB_PAD2 = 2'd2;  // two symbols and two pads

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  kind;
    logic        nl;
  } job_t;

  localparam logic       KIND_DATA  = 1'b0;
  localparam logic       KIND_FLUSH = 1'b1;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] NL_CHAR    = 8'h0A;
  localparam logic [7:0] GPL_RESET  = 8'd18;
  localparam logic [7:0] GOL_MAX    = 8'd255;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

@@ src/base64_encoder_line_wrap_core.sv @@
// Base64 encoder with line wrap: top level joining front end, queue and back end.
// Throughput: input words at one per cycle while the queue has room; the output port
// sends one character per cycle while out_ready allows; a group of three bytes gives 4 or 5 characters.
// Reset (rst, synchronous): empties the queue, clears pending bytes and line position,
// and sets groups_per_line to 18.
module base64_encoder_line_wrap_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  b64lw_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output b64lw_pkg::out_t  out_data,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data
);

  logic            push, pop, q_empty, q_full;
  b64lw_pkg::job_t push_job, head;

  b64lw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  b64lw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  b64lw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ src/b64lw_front.sv @@
// Front end: accepts words, holds pending bytes and the line position,
// and posts one group description per completed or flushed group. Uses b64lw_pkg.
module b64lw_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  b64lw_pkg::in_t   in_data,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  logic             q_full,
  output logic             push,
  output b64lw_pkg::job_t  push_job
);

  logic [7:0]  groups_per_line;
  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  held_count, held_count_next;
  logic [7:0]  groups_on_line, groups_on_line_next;
  logic [7:0]  gol_inc;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign gol_inc  = (groups_on_line == b64lw_pkg::GOL_MAX) ? groups_on_line
                                                          : groups_on_line + 8'd1;

  always_comb begin
    held_bytes_next     = held_bytes;
    held_count_next     = held_count;
    groups_on_line_next = groups_on_line;
    push                = 1'b0;
    push_job.bits       = {held_bytes, in_data.data_byte};
    push_job.kind       = b64lw_pkg::JOB_FULL;
    push_job.nl         = 1'b0;
    if (accept) begin
      if (in_data.kind == b64lw_pkg::KIND_DATA) begin
        if (held_count < 2'd2) begin
          held_bytes_next = {held_bytes[7:0], in_data.data_byte};
          held_count_next = held_count + 2'd1;
        end else begin
          push                = 1'b1;
          push_job.nl         = (gol_inc >= groups_per_line);
          groups_on_line_next = push_job.nl ? 8'd0 : gol_inc;
          held_bytes_next     = 16'd0;
          held_count_next     = 2'd0;
        end
      end else begin
        push        = (held_count != 2'd0);
        push_job.nl = (groups_on_line != 8'd0);
        if (held_count == 2'd1) begin
          push_job.bits = {held_bytes[7:0], 16'd0};
          push_job.kind = b64lw_pkg::JOB_PAD2;
        end else begin
          push_job.bits = {held_bytes, 8'd0};
          push_job.kind = b64lw_pkg::JOB_PAD1;
        end
        held_bytes_next     = 16'd0;
        held_count_next     = 2'd0;
        groups_on_line_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= b64lw_pkg::GPL_RESET;
      held_bytes      <= 16'd0;
      held_count      <= 2'd0;
      groups_on_line  <= 8'd0;
    end else begin
      if (cfg_write) begin
        groups_per_line <= cfg_data;
      end
      held_bytes     <= held_bytes_next;
      held_count     <= held_count_next;
      groups_on_line <= groups_on_line_next;
    end
  end

  // a posted group always leaves nothing pending
  assert property (@(posedge clk) disable iff (rst) push |=> held_count == 2'd0)
    else $error("pending bytes survive a posted group");
  assert property (@(posedge clk) disable iff (rst) held_count != 2'd3)
    else $error("pending byte count out of range");

endmodule

@@ src/b64lw_queue.sv @@
// Short queue of group descriptions between front and back end.
// Uses b64lw_pkg for the entry type.
module b64lw_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64lw_pkg::job_t  push_job,
  input  logic             pop,
  output b64lw_pkg::job_t  head,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64lw_pkg::job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("write into a full queue");
  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("read from an empty queue");

endmodule

@@ src/b64lw_back.sv @@
// Back end: expands the head group into characters, one per cycle while out_ready
// allows, into a registered output stage. Uses b64lw_pkg.
module b64lw_back (
  input  logic             clk,
  input  logic             rst,
  input  b64lw_pkg::job_t  head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output b64lw_pkg::out_t  out_data
);

  logic [2:0] pos;
  logic [2:0] nsym;
  logic [5:0] six;
  logic [7:0] ch;
  logic       is_last;
  logic       advance;

  always_comb begin
    case (head.kind)
      b64lw_pkg::JOB_FULL: nsym = 3'd4;
      b64lw_pkg::JOB_PAD1: nsym = 3'd3;
      b64lw_pkg::JOB_PAD2: nsym = 3'd2;
      default:             nsym = 3'd4;
    endcase
    case (pos)
      3'd0:    six = head.bits[23:18];
      3'd1:    six = head.bits[17:12];
      3'd2:    six = head.bits[11:6];
      default: six = head.bits[5:0];
    endcase
    if (pos == 3'd4) begin
      ch = b64lw_pkg::NL_CHAR;
    end else if (pos < nsym) begin
      ch = b64lw_pkg::b64_sym(six);
    end else begin
      ch = b64lw_pkg::PAD_CHAR;
    end
    is_last = head.nl ? (pos == 3'd4) : (pos == 3'd3);
  end

  assign advance = !empty && (!out_valid || out_ready);
  assign pop     = advance && is_last;

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.out_char <= ch;
      out_data.last     <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        pos       <= is_last ? 3'd0 : pos + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // a group's last word always carries the last flag
  assert property (@(posedge clk) disable iff (rst) pop |=> out_valid && out_data.last)
    else $error("group released without a last word");
  assert property (@(posedge clk) disable iff (rst) pos <= 3'd4)
    else $error("character position out of range");

endmodule

@@ tb/b64lw_char_checker.sv @@
`timescale 1ns / 1ps
// Character checker for the base64 line-wrap encoder: predicts the output words from
// the input words and register writes it observes, and compares them in order.
// Depends on b64lw_pkg for the word types and the character codes.
module b64lw_char_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  b64lw_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  b64lw_pkg::out_t out_data,
  input  logic            cfg_write,
  input  logic [7:0]      cfg_data,
  output int              mismatches,
  output int              chars_pending
);

  localparam logic [511:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [7:0]      line_groups;
  logic [15:0]     held_bytes;
  logic [1:0]      held_count;
  logic [7:0]      groups_on_line;
  b64lw_pkg::out_t expected_chars[$];

  function automatic logic [7:0] symbol(input logic [5:0] v);
    int idx;
    idx = v;
    return ALPHABET[511 - 8 * idx -: 8];
  endfunction

  // Advance the encoder state by one input word and queue the characters it gives
  task automatic encode_word(input b64lw_pkg::in_t w);
    logic [23:0]     bits;
    logic [7:0]      chars [5];
    int              n;
    b64lw_pkg::out_t item;
    n    = 0;
    bits = '0;
    if (w.kind == b64lw_pkg::KIND_DATA) begin
      if (held_count < 2'd2) begin
        held_bytes = {held_bytes[7:0], w.data_byte};
        held_count = held_count + 2'd1;
      end else begin
        bits     = {held_bytes, w.data_byte};
        chars[0] = symbol(bits[23:18]);
        chars[1] = symbol(bits[17:12]);
        chars[2] = symbol(bits[11:6]);
        chars[3] = symbol(bits[5:0]);
        n        = 4;
        if (groups_on_line != b64lw_pkg::GOL_MAX) begin
          groups_on_line = groups_on_line + 8'd1;
        end
        if (groups_on_line >= line_groups) begin
          chars[4]       = b64lw_pkg::NL_CHAR;
          n              = 5;
          groups_on_line = '0;
        end
        held_bytes = '0;
        held_count = '0;
      end
    end else begin
      if (held_count != 2'd0) begin
        bits     = (held_count == 2'd1) ? {held_bytes[7:0], 16'h0000} : {held_bytes, 8'h00};
        chars[0] = symbol(bits[23:18]);
        chars[1] = symbol(bits[17:12]);
        chars[2] = (held_count == 2'd1) ? b64lw_pkg::PAD_CHAR : symbol(bits[11:6]);
        chars[3] = b64lw_pkg::PAD_CHAR;
        n        = 4;
        // close the line only if full groups were already on it
        if (groups_on_line != 8'd0) begin
          chars[4] = b64lw_pkg::NL_CHAR;
          n        = 5;
        end
      end
      held_bytes     = '0;
      held_count     = '0;
      groups_on_line = '0;
    end
    for (int i = 0; i < n; i++) begin
      item.out_char  = chars[i];
      item.last      = (i == n - 1);
      expected_chars = {expected_chars, item};
    end
  endtask

  always @(posedge clk) begin : watch
    b64lw_pkg::out_t got;
    b64lw_pkg::out_t want;
    if (rst) begin
      line_groups    = b64lw_pkg::GPL_RESET;
      held_bytes     = '0;
      held_count     = '0;
      groups_on_line = '0;
      mismatches     = 0;
      expected_chars.delete();
    end else begin
      if (cfg_write) line_groups = cfg_data;
      if (out_valid && out_ready) begin
        got = out_data;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char %h last %b", $time, got.out_char, got.last);
          mismatches++;
        end else begin
          want = expected_chars.pop_front();
          if (got.out_char !== want.out_char || got.last !== want.last) begin
            $display("%0t: expected char %h last %b, got char %h last %b", $time,
                     want.out_char, want.last, got.out_char, got.last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) encode_word(in_data);
    end
    chars_pending <= expected_chars.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the base64 line-wrap encoder testbench: clock, reset, stimulus and verdict.
// Depends on b64lw_pkg, base64_encoder_line_wrap_core and b64lw_char_checker.
module testbench;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int LATENCY_WAIT = 8;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  b64lw_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  b64lw_pkg::out_t out_data;
  logic            cfg_write = 1'b0;
  logic [7:0]      cfg_data  = '0;

  int   mismatches;
  int   chars_pending;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   quiet_cycles = 0;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;

  always #5 clk = ~clk;

  base64_encoder_line_wrap_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  b64lw_char_checker char_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] data_byte);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, data_byte: data_byte};
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain every expected character, then allow for words still in flight
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chars_pending != 0) @(negedge clk);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  task automatic write_line_groups(input logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Messages of random length and content; now and then one is left open
  task automatic run_messages(input int words);
    int sent;
    int len;
    sent = 0;
    while (sent < words) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 8);
      for (int i = 0; i < len; i++) begin
        send_word(b64lw_pkg::KIND_DATA, 8'($urandom_range(255)));
      end
      if ($urandom_range(7) != 0) send_word(b64lw_pkg::KIND_FLUSH, 8'($urandom_range(255)));
      sent += len + 1;
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // reset line length: all-zero and all-one groups, empty flush
    repeat (3) send_word(b64lw_pkg::KIND_DATA, 8'h00);
    repeat (3) send_word(b64lw_pkg::KIND_DATA, 8'hFF);
    send_word(b64lw_pkg::KIND_FLUSH, 8'h00);
    send_word(b64lw_pkg::KIND_DATA, 8'h4D);
    send_word(b64lw_pkg::KIND_DATA, 8'h61);
    send_word(b64lw_pkg::KIND_DATA, 8'h6E);
    // one byte held, closing newline
    send_word(b64lw_pkg::KIND_DATA, 8'hFF);
    send_word(b64lw_pkg::KIND_FLUSH, 8'hA5);
    // two bytes held, line empty
    send_word(b64lw_pkg::KIND_DATA, 8'h80);
    send_word(b64lw_pkg::KIND_DATA, 8'h01);
    send_word(b64lw_pkg::KIND_FLUSH, 8'hFF);
    // two groups on the line, then lower the register to the count
    send_word(b64lw_pkg::KIND_DATA, 8'h14);
    send_word(b64lw_pkg::KIND_DATA, 8'hFB);
    send_word(b64lw_pkg::KIND_DATA, 8'h9C);
    send_word(b64lw_pkg::KIND_DATA, 8'h03);
    send_word(b64lw_pkg::KIND_DATA, 8'hD9);
    send_word(b64lw_pkg::KIND_DATA, 8'h7E);
    settle();
    write_line_groups(8'd2);
    send_word(b64lw_pkg::KIND_DATA, 8'h10);
    send_word(b64lw_pkg::KIND_DATA, 8'h51);
    send_word(b64lw_pkg::KIND_DATA, 8'h87);
    settle();
    // zero groups per line: newline after every full group
    write_line_groups(8'd0);
    send_word(b64lw_pkg::KIND_DATA, 8'h01);
    send_word(b64lw_pkg::KIND_DATA, 8'h02);
    send_word(b64lw_pkg::KIND_DATA, 8'h03);
    send_word(b64lw_pkg::KIND_DATA, 8'h04);
    send_word(b64lw_pkg::KIND_FLUSH, 8'h5A);
    settle();

    write_line_groups(8'd1);
    run_messages(16);
    settle();

    write_line_groups(8'd255);
    idle_pct = 58;
    run_messages(16);
    settle();

    write_line_groups(8'($urandom_range(2, 254)));
    idle_pct  = 0;
    stall_pct = 58;
    run_messages(16);
    settle();

    write_line_groups(8'($urandom_range(1, 254)));
    idle_pct  = 37;
    stall_pct = 37;
    run_messages(16);
    settle();

    // long receiver hold-off while words keep coming
    write_line_groups(8'd3);
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    run_messages(16);
    settle();

    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
